[rtl/core/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [2:0] EXT16_LEFT    = 3'd1;
    localparam logic [2:0] EXT64_LEFT    = 3'd7;
    localparam logic [2:0] KEY_LEFT      = 3'd3;
    localparam logic [3:0] OP_CONTROL    = 4'd8;
    localparam logic [3:0] OP_CONT       = 4'd0;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 10;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       valid;
        logic [3:0] opcode;
        logic [2:0] rsv;
        logic       fend;
        logic       mend;
        logic       err;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[rtl/core/wsd_front.sv]
// Header parser that accepts received bytes and queues classified result words.
module wsd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    output logic               in_ready,
    input  wsd_pkg::q_stat_t   q_stat,
    output logic               push,
    output wsd_pkg::q_entry_t  push_entry
);
    import wsd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [7:0]        header_first_reg, header_first_next;
    logic [2:0]        bytes_left_reg, bytes_left_next;
    logic [63:0]       remaining_reg, remaining_next;
    logic [3:0][7:0]   mask_key_reg, mask_key_next;
    logic              mask_en_reg, mask_en_next;
    logic [1:0]        key_lane_reg, key_lane_next;
    logic [3:0]        held_op_reg, held_op_next;
    logic [2:0]        held_rsv_reg, held_rsv_next;

    logic        fire;
    logic [6:0]  len7;
    logic        len_short;
    logic        ext_err;
    logic [63:0] rem_shift;
    logic [63:0] rem_dec;
    logic        hdr_done;
    logic        done_len_zero;
    logic [3:0]  hdr_op;
    logic [3:0]  tag_op;
    logic [2:0]  tag_rsv;

    assign in_ready  = !q_stat.full;
    assign fire      = in_valid && in_ready;
    assign len7      = in_byte[6:0];
    assign len_short = (len7 <= LEN_MAX_SHORT);
    assign ext_err   = (phase_reg == PH_EXTLEN) && (bytes_left_reg == EXT64_LEFT) && in_byte[7];
    assign rem_shift = {remaining_reg[55:0], in_byte};
    assign rem_dec   = remaining_reg - 64'd1;
    assign hdr_op    = header_first_reg[3:0];
    assign tag_op    = (hdr_op == OP_CONT) ? held_op_reg : hdr_op;
    assign tag_rsv   = (hdr_op == OP_CONT) ? held_rsv_reg : header_first_reg[6:4];

    always_comb begin
        hdr_done      = 1'b0;
        done_len_zero = 1'b0;
        case (phase_reg)
            PH_SECOND: begin
                hdr_done      = len_short && !in_byte[7];
                done_len_zero = (len7 == 7'd0);
            end
            PH_EXTLEN: begin
                hdr_done      = !ext_err && (bytes_left_reg == 3'd0) && !mask_en_reg;
                done_len_zero = (rem_shift == 64'd0);
            end
            PH_KEY: begin
                hdr_done      = (bytes_left_reg == 3'd0);
                done_len_zero = (remaining_reg == 64'd0);
            end
            default: begin
                hdr_done      = 1'b0;
                done_len_zero = 1'b0;
            end
        endcase
        hdr_done = hdr_done && fire;
    end

    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            case (phase_reg)
                PH_SECOND: begin
                    if (!len_short) begin
                        phase_next = PH_EXTLEN;
                    end else if (in_byte[7]) begin
                        phase_next = PH_KEY;
                    end else begin
                        phase_next = (len7 == 7'd0) ? PH_FIRST : PH_PAYLOAD;
                    end
                end
                PH_EXTLEN: begin
                    if (ext_err) begin
                        phase_next = PH_ERROR;
                    end else if (bytes_left_reg == 3'd0) begin
                        if (mask_en_reg) begin
                            phase_next = PH_KEY;
                        end else begin
                            phase_next = (rem_shift == 64'd0) ? PH_FIRST : PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    if (bytes_left_reg == 3'd0) begin
                        phase_next = (remaining_reg == 64'd0) ? PH_FIRST : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (rem_dec == 64'd0) begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_ERROR: begin
                    phase_next = PH_ERROR;
                end
                default: begin
                    phase_next = PH_SECOND;
                end
            endcase
        end
    end

    always_comb begin
        header_first_next = header_first_reg;
        bytes_left_next   = bytes_left_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        mask_en_next      = mask_en_reg;
        key_lane_next     = key_lane_reg;
        held_op_next      = held_op_reg;
        held_rsv_next     = held_rsv_reg;
        push              = 1'b0;
        push_entry        = '0;
        push_entry.opcode = tag_op;
        push_entry.rsv    = tag_rsv;
        if (fire) begin
            case (phase_reg)
                PH_SECOND: begin
                    mask_en_next   = in_byte[7];
                    remaining_next = {57'd0, len7};
                    if (!len_short) begin
                        remaining_next  = 64'd0;
                        bytes_left_next = (len7 == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
                    end else if (in_byte[7]) begin
                        bytes_left_next = KEY_LEFT;
                        mask_key_next   = '0;
                    end
                end
                PH_EXTLEN: begin
                    if (!ext_err) begin
                        remaining_next = rem_shift;
                        if (bytes_left_reg == 3'd0) begin
                            if (mask_en_reg) begin
                                bytes_left_next = KEY_LEFT;
                                mask_key_next   = '0;
                            end
                        end else begin
                            bytes_left_next = bytes_left_reg - 3'd1;
                        end
                    end
                end
                PH_KEY: begin
                    mask_key_next = {mask_key_reg[2:0], in_byte};
                    if (bytes_left_reg != 3'd0) begin
                        bytes_left_next = bytes_left_reg - 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    remaining_next    = rem_dec;
                    key_lane_next     = key_lane_reg + 2'd1;
                    push              = 1'b1;
                    push_entry.data   = in_byte;
                    push_entry.key    = mask_en_reg ? mask_key_reg[~key_lane_reg] : 8'd0;
                    push_entry.valid  = 1'b1;
                    push_entry.fend   = (rem_dec == 64'd0);
                    push_entry.mend   = (rem_dec == 64'd0) && header_first_reg[7];
                end
                PH_ERROR: begin
                end
                default: begin
                    header_first_next = in_byte;
                end
            endcase

            if (phase_reg == PH_ERROR || ext_err) begin
                push       = 1'b1;
                push_entry = '0;
                push_entry.err = 1'b1;
            end

            if (hdr_done) begin
                key_lane_next = 2'd0;
                if (hdr_op != OP_CONT && hdr_op < OP_CONTROL) begin
                    held_op_next  = hdr_op;
                    held_rsv_next = header_first_reg[6:4];
                end
                if (done_len_zero) begin
                    push            = 1'b1;
                    push_entry.fend = 1'b1;
                    push_entry.mend = header_first_reg[7];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_FIRST;
            header_first_reg <= '0;
            bytes_left_reg   <= '0;
            remaining_reg    <= '0;
            mask_key_reg     <= '0;
            mask_en_reg      <= 1'b0;
            key_lane_reg     <= '0;
            held_op_reg      <= '0;
            held_rsv_reg     <= '0;
        end else begin
            phase_reg        <= phase_next;
            header_first_reg <= header_first_next;
            bytes_left_reg   <= bytes_left_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            mask_en_reg      <= mask_en_next;
            key_lane_reg     <= key_lane_next;
            held_op_reg      <= held_op_next;
            held_rsv_reg     <= held_rsv_next;
        end
    end

endmodule

[rtl/core/wsd_queue.sv]
// Small first-in first-out queue of result words between parser and output stage.
module wsd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  wsd_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output wsd_pkg::q_entry_t  head,
    output wsd_pkg::q_stat_t   stat
);
    import wsd_pkg::*;

    q_entry_t          slots [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + Q_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/wsd_back.sv]
// Output stage that unmasks queued payload bytes and holds the outgoing word.
module wsd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wsd_pkg::q_entry_t                 head,
    input  wsd_pkg::q_stat_t                  q_stat,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [wsd_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);
    import wsd_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_DATA_W-1:0]  data_reg, data_next;
    logic [OUT_USER_W-1:0]  user_reg, user_next;
    logic                   last_reg, last_next;

    assign pop = !q_stat.empty && (!valid_reg || m_axis_tready);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (pop) begin
            valid_next = 1'b1;
            data_next  = head.data ^ head.key;
            user_next  = {head.err, head.mend, head.rsv, head.opcode, head.valid};
            last_next  = head.fend;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule

[rtl/core/websocket_frame_deframer.sv]
// Top level of the WebSocket receive frame deframer.
//
// The s_axis channel takes the received frame stream one byte per word. The block
// parses each frame header and gives one m_axis word per payload byte, unmasked and
// tagged with the message opcode and RSV bits. A frame with no payload gives one word
// with the data-valid flag clear on the byte that completes its header.
// m_axis_tlast marks the last word of a frame, and the message-end flag in tuser is set
// there when the frame had FIN. A 64-bit length with its top bit set latches an error:
// from then on every input byte gives one error word, until reset.
// Throughput is one byte per cycle while the queue is not full; header and length bytes
// are parsed as they are accepted. A result is written into the four-entry queue when
// its byte is accepted and then moves to the output register that drives m_axis.
// When the receiver stalls, the queue fills and s_axis_tready drops once it is full.
// Synchronous reset clears the parser to wait for a header byte and empties the queue.
module websocket_frame_deframer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // data_byte
    // data_valid, message_opcode[4:1], message_rsv[7:5], message_end, error_code
    output logic [wsd_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast    // frame_end
);
    import wsd_pkg::*;

    q_stat_t   q_stat;
    q_entry_t  push_entry;
    q_entry_t  head;
    logic      push;
    logic      pop;

    wsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_ready   (s_axis_tready),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    wsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    wsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_error_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[9] |->
            m_axis_tuser[8:0] == '0 && m_axis_tdata == '0 && !m_axis_tlast)
        else $error("error word carries payload or tags");

    a_empty_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("word without payload has nonzero data");

    a_end_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[8] |-> m_axis_tlast)
        else $error("message end outside the last word of a frame");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
